### hw/rtl/mbps_pkg.sv
// Shared constants, register codes and types of the masked byte pattern search.
package mbps_pkg;

   // Window depth in bytes and width of the byte position count
   localparam int MAX_PATTERN_BYTES = 32;
   localparam int OFFSET_BITS       = 32;

   // Fixed field and register widths
   localparam int DATA_BITS       = 8;
   localparam int RSP_OFFSET_BITS = 32;
   localparam int REG_BYTES       = 32;   // pattern bytes held in the registers
   localparam int CARE_BITS       = 32;
   localparam int LEN_BITS        = 6;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 64;

   // Derived sizes
   localparam int WIN_BITS  = MAX_PATTERN_BYTES * DATA_BITS;
   localparam int IDX_BITS  = $clog2(MAX_PATTERN_BYTES);
   localparam int FILL_BITS = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int PAT_BITS  = REG_BYTES * DATA_BITS;

   // Register reset values
   localparam logic [CARE_BITS-1:0] CARE_MASK_RESET      = 32'h0180_6841;
   localparam logic [LEN_BITS-1:0]  PATTERN_LENGTH_RESET = 6'd25;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_0      = 3'd0,
      CSR_PATTERN_1      = 3'd1,
      CSR_PATTERN_2      = 3'd2,
      CSR_PATTERN_3      = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5
   } csr_index_type;

   // Configuration seen by the compare logic
   typedef struct packed {
      logic [PAT_BITS-1:0]  pattern;   // byte 0 in bits 7:0
      logic [CARE_BITS-1:0] care;
      logic [LEN_BITS-1:0]  length;
   } cfg_type;

   // Window state of the most recent transfer
   typedef struct packed {
      logic [WIN_BITS-1:0]    bytes;   // newest byte in bits 7:0
      logic [FILL_BITS-1:0]   fill;
      logic [OFFSET_BITS-1:0] pos;
      logic                   last;
   } win_type;

endpackage

### hw/rtl/mbps_cfg.sv
// Configuration register file: pattern bytes, care mask and pattern length.
module mbps_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]  wr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]   wr_data,
   output mbps_pkg::cfg_type                    cfg
);

   logic [mbps_pkg::PAT_BITS-1:0]  pattern_ff, pattern_in;
   logic [mbps_pkg::CARE_BITS-1:0] care_ff, care_in;
   logic [mbps_pkg::LEN_BITS-1:0]  length_ff, length_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      pattern_in = pattern_ff;
      care_in    = care_ff;
      length_in  = length_ff;
      if (wr_en) begin
         case (wr_index)
            mbps_pkg::CSR_PATTERN_0:      pattern_in[63:0]    = wr_data;
            mbps_pkg::CSR_PATTERN_1:      pattern_in[127:64]  = wr_data;
            mbps_pkg::CSR_PATTERN_2:      pattern_in[191:128] = wr_data;
            mbps_pkg::CSR_PATTERN_3:      pattern_in[255:192] = wr_data;
            mbps_pkg::CSR_CARE_MASK:      care_in   = wr_data[mbps_pkg::CARE_BITS-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH: length_in = wr_data[mbps_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= mbps_pkg::CARE_MASK_RESET;
         length_ff  <= mbps_pkg::PATTERN_LENGTH_RESET;
      end else begin
         pattern_ff <= pattern_in;
         care_ff    <= care_in;
         length_ff  <= length_in;
      end
   end

   assign cfg.pattern = pattern_ff;
   assign cfg.care    = care_ff;
   assign cfg.length  = length_ff;

endmodule

### hw/rtl/mbps_window.sv
// Sliding byte window with position and fill counters, restarted after a last byte.
module mbps_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [mbps_pkg::DATA_BITS-1:0] data_byte,
   input  logic                           last_byte,
   output mbps_pkg::win_type              win
);

   localparam logic [mbps_pkg::FILL_BITS-1:0] FILL_FULL =
      mbps_pkg::FILL_BITS'(mbps_pkg::MAX_PATTERN_BYTES);

   logic [mbps_pkg::WIN_BITS-1:0]    bytes_ff, bytes_in;
   logic [mbps_pkg::FILL_BITS-1:0]   fill_ff, fill_in, base_fill;
   logic [mbps_pkg::OFFSET_BITS-1:0] pos_ff, pos_in, base_pos;
   logic                             last_ff, last_in;

   // A new buffer starts counting from zero after a last byte
   always_comb begin
      base_fill = last_ff ? '0 : fill_ff;
      base_pos  = last_ff ? '0 : pos_ff;
      bytes_in  = bytes_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      last_in   = last_ff;
      if (load) begin
         bytes_in = {bytes_ff[mbps_pkg::WIN_BITS-mbps_pkg::DATA_BITS-1:0], data_byte};
         fill_in  = (base_fill == FILL_FULL) ? base_fill
                                             : base_fill + mbps_pkg::FILL_BITS'(1);
         pos_in   = base_pos + mbps_pkg::OFFSET_BITS'(1);
         last_in  = last_byte;
      end
   end

   // Window bytes are payload; the fill count gates their use
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
         last_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         last_ff <= last_in;
      end
   end

   assign win.bytes = bytes_ff;
   assign win.fill  = fill_ff;
   assign win.pos   = pos_ff;
   assign win.last  = last_ff;

endmodule

### hw/rtl/mbps_match.sv
// Parallel masked compare of the window against the pattern, and start offset.
module mbps_match (
   input  mbps_pkg::cfg_type                    cfg,
   input  mbps_pkg::win_type                    win,
   output logic                                 hit,
   output logic [mbps_pkg::RSP_OFFSET_BITS-1:0] match_offset
);

   localparam logic [mbps_pkg::LEN_BITS-1:0] LEN_MAX =
      mbps_pkg::LEN_BITS'(mbps_pkg::MAX_PATTERN_BYTES);

   logic [mbps_pkg::LEN_BITS-1:0]          len_eff;
   logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] byte_ok;
   logic [mbps_pkg::OFFSET_BITS-1:0]       start_pos;

   // Clamp the length to 1..MAX_PATTERN_BYTES
   always_comb begin
      if (cfg.length == '0) begin
         len_eff = mbps_pkg::LEN_BITS'(1);
      end else if (cfg.length > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = cfg.length;
      end
   end

   // Pattern byte i lines up with window entry len-1-i
   always_comb begin
      logic [mbps_pkg::LEN_BITS-1:0]  widx;
      logic [mbps_pkg::DATA_BITS-1:0] wbyte;
      logic [mbps_pkg::DATA_BITS-1:0] pbyte;
      logic                           needed;
      for (int i = 0; i < mbps_pkg::MAX_PATTERN_BYTES; i++) begin
         widx   = len_eff - mbps_pkg::LEN_BITS'(1) - mbps_pkg::LEN_BITS'(i);
         wbyte  = win.bytes[{widx[mbps_pkg::IDX_BITS-1:0], 3'b000} +: mbps_pkg::DATA_BITS];
         pbyte  = '0;
         needed = (i == 0);
         if (i < mbps_pkg::REG_BYTES) begin
            pbyte = cfg.pattern[i*mbps_pkg::DATA_BITS +: mbps_pkg::DATA_BITS];
         end
         if (i < mbps_pkg::CARE_BITS && i != 0) begin
            needed = cfg.care[i];
         end
         byte_ok[i] = (mbps_pkg::LEN_BITS'(i) >= len_eff) || !needed || (wbyte == pbyte);
      end
   end

   assign hit = (win.fill >= mbps_pkg::FILL_BITS'(len_eff)) && (&byte_ok);

   assign start_pos    = win.pos - mbps_pkg::OFFSET_BITS'(len_eff);
   assign match_offset = mbps_pkg::RSP_OFFSET_BITS'(start_pos);

endmodule

### hw/rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search.
//
// Bytes of a buffer arrive on the req channel, one per transfer, with tlast
// on the final byte. Each byte shifts into a window of the newest
// MAX_PATTERN_BYTES bytes, and the newest pattern_length bytes are compared
// against the pattern; byte 0 always counts, byte i only with care_mask bit i.
// The first match of a buffer gives one rsp transfer with tuser (found) = 1
// and the start offset in tdata. A buffer that ends with no match gives one
// transfer with found = 0 and offset 0. Other bytes give nothing.
// A result passes through the window register, then the compare into the result
// register. Throughput: one byte per cycle while the result register can take
// results, set by the single compare stage after the window register.
// The csr port writes the six registers, always ready;
// write it only while no bytes are in flight.
// Reset (synchronous) restores the register defaults and starts a new buffer.
// When rsp_tready is low with a result waiting, the byte behind it is still
// taken; further bytes wait until the result is transferred.
module masked_byte_pattern_search (
   input  logic                                 clock,
   input  logic                                 reset,
   // req: tdata = data_byte[7:0]; tlast = last_byte
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,
   input  logic                                 req_tlast,
   // rsp: tdata = match_offset[31:0]; tuser = found
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,
   output logic                                 rsp_tuser,
   // csr write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   mbps_pkg::cfg_type cfg;
   mbps_pkg::win_type win;

   logic                                 req_accept;
   logic                                 out_free;
   logic                                 eval_fire;
   logic                                 match_hit;
   logic                                 hit;
   logic                                 emit;
   logic [mbps_pkg::RSP_OFFSET_BITS-1:0] match_offset;

   logic                                 eval_valid_ff, eval_valid_in;
   logic                                 reported_ff, reported_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [mbps_pkg::RSP_OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;

   assign csr_ready = 1'b1;

   mbps_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   mbps_window u_window (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .win       (win)
   );

   mbps_match u_match (
      .cfg          (cfg),
      .win          (win),
      .hit          (match_hit),
      .match_offset (match_offset)
   );

   // Handshake: the compare stage moves when the result register can take it
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign eval_fire  = eval_valid_ff && out_free;
   assign req_tready = !eval_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // Result decision for the byte in the compare stage
   assign hit  = match_hit && !reported_ff;
   assign emit = hit || (win.last && !reported_ff);

   always_comb begin
      eval_valid_in = eval_valid_ff;
      reported_in   = reported_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (eval_fire) begin
         eval_valid_in = 1'b0;
         reported_in   = win.last ? 1'b0 : (reported_ff || hit);
      end
      if (req_accept) begin
         eval_valid_in = 1'b1;
      end
      if (out_free) begin
         rsp_valid_in = eval_fire && emit;
      end
      if (eval_fire && emit) begin
         rsp_found_in  = hit;
         rsp_offset_in = hit ? match_offset : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
         reported_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eval_valid_ff <= eval_valid_in;
         reported_ff   <= reported_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

### hw/rtl/mbps_checker.sv
// Port-level checks of the masked byte pattern search, bound to the top level.
module mbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A waiting result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // A no-match result carries offset zero
   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("no-match result with nonzero offset");

   // A fresh result follows a byte transfer through the window register and compare
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a byte two cycles before");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
